[rtl/qsau_pkg.sv]
// ============================================================================
// qsau_pkg: shared types and constants for the quaternion small-angle update
// Fixed-point format, pipeline latencies and the side-data record that
// travels down the top-level pipeline next to the arithmetic.
// ============================================================================
package qsau_pkg;

    // Q2.30 fixed point
    localparam int FRAC_BITS  = 30;
    localparam int SQRT_STEPS = FRAC_BITS + 1;   // root bits produced
    localparam int DIV_STEPS  = FRAC_BITS + 1;   // quotient bits produced

    // unitize: abs, max, shift, square, sum, sqrt, divide, sign
    localparam int UNIT_LAT = 5 + SQRT_STEPS + DIV_STEPS + 1;
    localparam int HAM_LAT  = 3;

    // side-chain taps (cycle index after accept)
    localparam int W_TAP  = 2 + SQRT_STEPS;
    localparam int DU_TAP = W_TAP + UNIT_LAT;
    localparam int R_TAP  = DU_TAP + HAM_LAT + UNIT_LAT;

    typedef logic signed [31:0] q_t;
    typedef logic signed [65:0] wide_t;

    typedef struct packed {
        logic valid;
        logic pass;
        logic clamped;
        q_t   qx;
        q_t   qy;
        q_t   qz;
        q_t   qw;
        q_t   dx;
        q_t   dy;
        q_t   dz;
    } side_t;

endpackage

[rtl/qsau_in_if.sv]
// ============================================================================
// qsau_in_if: input channel
// Quaternion and rotation increment, valid/ready handshake.
// ============================================================================
interface qsau_in_if;
    import qsau_pkg::*;

    logic valid;
    logic ready;
    q_t   in_qx;
    q_t   in_qy;
    q_t   in_qz;
    q_t   in_qw;
    q_t   delta_x;
    q_t   delta_y;
    q_t   delta_z;

    modport source (output valid, in_qx, in_qy, in_qz, in_qw, delta_x, delta_y, delta_z,
                    input ready);
    modport sink   (input valid, in_qx, in_qy, in_qz, in_qw, delta_x, delta_y, delta_z,
                    output ready);
endinterface

[rtl/qsau_out_if.sv]
// ============================================================================
// qsau_out_if: result channel
// Updated quaternion and status flags, valid/ready handshake.
// ============================================================================
interface qsau_out_if;
    import qsau_pkg::*;

    logic valid;
    logic ready;
    q_t   out_qx;
    q_t   out_qy;
    q_t   out_qz;
    q_t   out_qw;
    logic passed_through;
    logic norm_clamped;

    modport source (output valid, out_qx, out_qy, out_qz, out_qw, passed_through,
                    norm_clamped, input ready);
    modport sink   (input valid, out_qx, out_qy, out_qz, out_qw, passed_through,
                    norm_clamped, output ready);
endinterface

[rtl/quaternion_small_angle_update_top.sv]
// ============================================================================
// quaternion_small_angle_update_top: quaternion small-angle update
// Throughput: one update per cycle; the whole pipeline holds while a
// finished result waits, set by the single output register.
// Depth is set by the bit-serial square roots (one for w, one in each
// normalizer) and the one-bit-per-stage dividers. Reset clears valid bits
// and yaw_only.
// ============================================================================
module quaternion_small_angle_update_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    qsau_in_if.sink      in_ch,
    qsau_out_if.source   out_ch
);
    import qsau_pkg::*;

    logic  yaw_only_reg;
    logic  en;
    side_t side_reg [1:R_TAP];
    side_t side_next;
    side_t side2_next;
    logic  clamped_next;

    logic signed [63:0] sqx_reg, sqy_reg, sqz_reg;
    logic [63:0] s_sum;
    logic [63:0] rad_reg;
    logic [63:0] hi;
    logic [FRAC_BITS:0] sf, wsq;
    logic [SQRT_STEPS-1:0] w30;

    wide_t c1 [4];
    q_t    du [4];
    logic signed [63:0] pr_reg [4][4];
    wide_t ha_reg [4];
    wide_t hb_reg [4];
    wide_t p_reg  [4];
    q_t    r [4];

    logic out_valid_reg;
    q_t   oqx_reg, oqy_reg, oqz_reg, oqw_reg;
    logic opass_reg, oclamp_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            yaw_only_reg <= 1'b0;
        else if (cfg_we)
            yaw_only_reg <= cfg_wdata;
    end

    // global advance: pipeline moves unless the result is held
    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    // stage 1 capture: mask increments, flag zero increment
    always_comb
    begin
        side_next.valid   = in_ch.valid;
        side_next.qx      = in_ch.in_qx;
        side_next.qy      = in_ch.in_qy;
        side_next.qz      = in_ch.in_qz;
        side_next.qw      = in_ch.in_qw;
        side_next.dx      = yaw_only_reg ? q_t'(0) : in_ch.delta_x;
        side_next.dy      = yaw_only_reg ? q_t'(0) : in_ch.delta_y;
        side_next.dz      = in_ch.delta_z;
        side_next.pass    = (side_next.dx == '0) && (side_next.dy == '0)
                          && (side_next.dz == '0);
        side_next.clamped = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= 64'(side_next.dx) * 64'(side_next.dx);
            sqy_reg <= 64'(side_next.dy) * 64'(side_next.dy);
            sqz_reg <= 64'(side_next.dz) * 64'(side_next.dz);
        end
    end

    // stage 2: squared norm, clamp, w^2 = 1 - s/4
    always_comb
    begin
        s_sum        = 64'(sqx_reg) + 64'(sqy_reg) + 64'(sqz_reg);
        clamped_next = s_sum > (64'd1 << (2 * FRAC_BITS));
        hi           = s_sum >> FRAC_BITS;
        sf           = clamped_next ? (FRAC_BITS+1)'(1) << FRAC_BITS
                                    : hi[FRAC_BITS:0];
        wsq          = ((FRAC_BITS+1)'(1) << FRAC_BITS) - (sf >> 2);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rad_reg <= 64'(wsq) << FRAC_BITS;
    end

    // clamp flag joins the side data at stage 2
    always_comb
    begin
        side2_next         = side_reg[1];
        side2_next.clamped = clamped_next;
    end

    // side data travels with the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= R_TAP; i++)
                side_reg[i] <= '0;
        end
        else if (en)
        begin
            side_reg[1] <= side_next;
            side_reg[2] <= side2_next;
            for (int i = 3; i <= R_TAP; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    qsau_sqrt u_wsqrt (
        .clk  (clk),
        .en   (en),
        .rad  (rad_reg),
        .root (w30)
    );

    // delta vector (2w, dx, dy, dz)
    assign c1[0] = wide_t'({34'd0, w30, 1'b0});
    assign c1[1] = wide_t'(side_reg[W_TAP].dx);
    assign c1[2] = wide_t'(side_reg[W_TAP].dy);
    assign c1[3] = wide_t'(side_reg[W_TAP].dz);

    qsau_unitize u_unit_d (
        .clk (clk),
        .en  (en),
        .c   (c1),
        .u   (du)
    );

    // Hamilton product: products, pair sums, final sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg[0][0] <= 64'(du[0]) * 64'(side_reg[DU_TAP].qw);
            pr_reg[0][1] <= 64'(du[1]) * 64'(side_reg[DU_TAP].qx);
            pr_reg[0][2] <= 64'(du[2]) * 64'(side_reg[DU_TAP].qy);
            pr_reg[0][3] <= 64'(du[3]) * 64'(side_reg[DU_TAP].qz);
            pr_reg[1][0] <= 64'(du[0]) * 64'(side_reg[DU_TAP].qx);
            pr_reg[1][1] <= 64'(du[1]) * 64'(side_reg[DU_TAP].qw);
            pr_reg[1][2] <= 64'(du[2]) * 64'(side_reg[DU_TAP].qz);
            pr_reg[1][3] <= 64'(du[3]) * 64'(side_reg[DU_TAP].qy);
            pr_reg[2][0] <= 64'(du[0]) * 64'(side_reg[DU_TAP].qy);
            pr_reg[2][1] <= 64'(du[1]) * 64'(side_reg[DU_TAP].qz);
            pr_reg[2][2] <= 64'(du[2]) * 64'(side_reg[DU_TAP].qw);
            pr_reg[2][3] <= 64'(du[3]) * 64'(side_reg[DU_TAP].qx);
            pr_reg[3][0] <= 64'(du[0]) * 64'(side_reg[DU_TAP].qz);
            pr_reg[3][1] <= 64'(du[1]) * 64'(side_reg[DU_TAP].qy);
            pr_reg[3][2] <= 64'(du[2]) * 64'(side_reg[DU_TAP].qx);
            pr_reg[3][3] <= 64'(du[3]) * 64'(side_reg[DU_TAP].qw);

            ha_reg[0] <= wide_t'(pr_reg[0][0]) - wide_t'(pr_reg[0][1]);
            hb_reg[0] <= -wide_t'(pr_reg[0][2]) - wide_t'(pr_reg[0][3]);
            ha_reg[1] <= wide_t'(pr_reg[1][0]) + wide_t'(pr_reg[1][1]);
            hb_reg[1] <= wide_t'(pr_reg[1][2]) - wide_t'(pr_reg[1][3]);
            ha_reg[2] <= wide_t'(pr_reg[2][0]) - wide_t'(pr_reg[2][1]);
            hb_reg[2] <= wide_t'(pr_reg[2][2]) + wide_t'(pr_reg[2][3]);
            ha_reg[3] <= wide_t'(pr_reg[3][0]) + wide_t'(pr_reg[3][1]);
            hb_reg[3] <= -wide_t'(pr_reg[3][2]) + wide_t'(pr_reg[3][3]);

            for (int i = 0; i < 4; i++)
                p_reg[i] <= ha_reg[i] + hb_reg[i];
        end
    end

    qsau_unitize u_unit_p (
        .clk (clk),
        .en  (en),
        .c   (p_reg),
        .u   (r)
    );

    // output register: pass-through select, w made nonnegative
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= side_reg[R_TAP].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            opass_reg  <= side_reg[R_TAP].pass;
            oclamp_reg <= side_reg[R_TAP].clamped && !side_reg[R_TAP].pass;
            if (side_reg[R_TAP].pass)
            begin
                oqx_reg <= side_reg[R_TAP].qx;
                oqy_reg <= side_reg[R_TAP].qy;
                oqz_reg <= side_reg[R_TAP].qz;
                oqw_reg <= side_reg[R_TAP].qw;
            end
            else if (r[0][31])
            begin
                oqx_reg <= -r[1];
                oqy_reg <= -r[2];
                oqz_reg <= -r[3];
                oqw_reg <= -r[0];
            end
            else
            begin
                oqx_reg <= r[1];
                oqy_reg <= r[2];
                oqz_reg <= r[3];
                oqw_reg <= r[0];
            end
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.out_qx         = oqx_reg;
    assign out_ch.out_qy         = oqy_reg;
    assign out_ch.out_qz         = oqz_reg;
    assign out_ch.out_qw         = oqw_reg;
    assign out_ch.passed_through = opass_reg;
    assign out_ch.norm_clamped   = oclamp_reg;
endmodule

[rtl/qsau_sqrt.sv]
// ============================================================================
// qsau_sqrt: pipelined integer square root
// floor(sqrt(rad)), one root bit per stage, SQRT_STEPS stages.
// ============================================================================
module qsau_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] rad,
    output logic [qsau_pkg::SQRT_STEPS-1:0] root
);
    import qsau_pkg::*;

    logic [63:0]           rem_w   [SQRT_STEPS+1];
    logic [SQRT_STEPS-1:0] root_w  [SQRT_STEPS+1];
    logic [63:0]           rem_reg [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] root_reg[SQRT_STEPS];

    assign rem_w[0]  = rad;
    assign root_w[0] = '0;

    genvar k;
    generate
        for (k = 0; k < SQRT_STEPS; k++)
        begin : g_step
            localparam int B = SQRT_STEPS - 1 - k;
            logic [63:0]           trial;
            logic [63:0]           rem_next;
            logic [SQRT_STEPS-1:0] root_next;

            // try setting root bit B: (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
            always_comb
            begin
                trial = (64'(root_w[k]) << (B + 1)) + (64'd1 << (2 * B));
                if (rem_w[k] >= trial)
                begin
                    rem_next  = rem_w[k] - trial;
                    root_next = root_w[k] | (SQRT_STEPS'(1) << B);
                end
                else
                begin
                    rem_next  = rem_w[k];
                    root_next = root_w[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                end
            end

            assign rem_w[k+1]  = rem_reg[k];
            assign root_w[k+1] = root_reg[k];
        end
    endgenerate

    assign root = root_w[SQRT_STEPS];
endmodule

[rtl/qsau_unitize.sv]
// ============================================================================
// qsau_unitize: pipelined 4-vector normalizer
// Scales magnitudes so the largest lies in [2^29, 2^30), takes the root of
// the sum of squares and divides each component by it, rounding half up.
// One vector per cycle while en is high.
// ============================================================================
module qsau_unitize (
    input  logic              clk,
    input  logic              en,
    input  qsau_pkg::wide_t   c [4],
    output qsau_pkg::q_t      u [4]
);
    import qsau_pkg::*;

    typedef struct packed {
        logic [3:0][FRAC_BITS-1:0] m;
        logic [3:0]                neg;
        logic                      zero;
    } usd_t;

    localparam int DLY = 3 + SQRT_STEPS - 1;

    logic [65:0] mag1_reg [4];
    logic [3:0]  neg1_reg;
    logic [65:0] mag2_reg [4];
    logic [65:0] mx2_reg;
    logic [3:0]  neg2_reg;
    usd_t        u3_reg;
    logic [2*FRAC_BITS-1:0] sq4_reg [4];
    logic [63:0] n2_reg;
    usd_t        dl_reg [DLY];
    logic [SQRT_STEPS-1:0] n_root;

    logic [65:0] mx_a, mx_b, mx_c;
    logic [6:0]  pos;
    logic [6:0]  rs, ls;
    usd_t        u3_next;

    // stage 1: magnitude and sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mag1_reg[i] <= c[i][65] ? 66'(-c[i]) : 66'(c[i]);
                neg1_reg[i] <= c[i][65];
            end
        end
    end

    // stage 2: largest magnitude
    assign mx_a = (mag1_reg[0] > mag1_reg[1]) ? mag1_reg[0] : mag1_reg[1];
    assign mx_b = (mag1_reg[2] > mag1_reg[3]) ? mag1_reg[2] : mag1_reg[3];
    assign mx_c = (mx_a > mx_b) ? mx_a : mx_b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag2_reg <= mag1_reg;
            mx2_reg  <= mx_c;
            neg2_reg <= neg1_reg;
        end
    end

    // stage 3: bring the largest into [2^29, 2^30)
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < 66; i++)
            if (mx2_reg[i])
                pos = 7'(i);
        rs = (pos >= 7'(FRAC_BITS)) ? pos - 7'(FRAC_BITS - 1) : '0;
        ls = (pos < 7'(FRAC_BITS - 1)) ? 7'(FRAC_BITS - 1) - pos : '0;
        u3_next.neg  = neg2_reg;
        u3_next.zero = (mx2_reg == '0);
        for (int i = 0; i < 4; i++)
            u3_next.m[i] = FRAC_BITS'((mag2_reg[i] >> rs) << ls);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            u3_reg <= u3_next;
    end

    // stage 4: squares; stage 5: sum of squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
                sq4_reg[i] <= 60'(u3_reg.m[i]) * 60'(u3_reg.m[i]);
            n2_reg <= 64'(sq4_reg[0]) + 64'(sq4_reg[1])
                    + 64'(sq4_reg[2]) + 64'(sq4_reg[3]);
        end
    end

    // components wait alongside the root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_reg[0] <= u3_reg;
            for (int i = 1; i < DLY; i++)
                dl_reg[i] <= dl_reg[i-1];
        end
    end

    qsau_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (n2_reg),
        .root (n_root)
    );

    // restoring divide, one quotient bit per stage, four lanes
    logic [63:0]          drem_w [DIV_STEPS+1][4];
    logic [DIV_STEPS-1:0] dquo_w [DIV_STEPS+1][4];
    logic [SQRT_STEPS-1:0] dn_w  [DIV_STEPS+1];
    logic [3:0]           dneg_w [DIV_STEPS+1];
    logic                 dz_w   [DIV_STEPS+1];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            drem_w[0][i] = (64'(dl_reg[DLY-1].m[i]) << FRAC_BITS) + 64'(n_root >> 1);
            dquo_w[0][i] = '0;
        end
    end
    assign dn_w[0]   = n_root;
    assign dneg_w[0] = dl_reg[DLY-1].neg;
    assign dz_w[0]   = dl_reg[DLY-1].zero;

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_div
            localparam int QB = DIV_STEPS - 1 - k;
            logic [63:0]           dsh;
            logic [63:0]           rem_next [4];
            logic [DIV_STEPS-1:0]  quo_next [4];
            logic [63:0]           rem_reg  [4];
            logic [DIV_STEPS-1:0]  quo_reg  [4];
            logic [SQRT_STEPS-1:0] n_reg;
            logic [3:0]            neg_reg;
            logic                  z_reg;

            always_comb
            begin
                dsh = 64'(dn_w[k]) << QB;
                for (int i = 0; i < 4; i++)
                begin
                    if (drem_w[k][i] >= dsh)
                    begin
                        rem_next[i] = drem_w[k][i] - dsh;
                        quo_next[i] = dquo_w[k][i] | (DIV_STEPS'(1) << QB);
                    end
                    else
                    begin
                        rem_next[i] = drem_w[k][i];
                        quo_next[i] = dquo_w[k][i];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    n_reg   <= dn_w[k];
                    neg_reg <= dneg_w[k];
                    z_reg   <= dz_w[k];
                end
            end

            assign drem_w[k+1] = rem_reg;
            assign dquo_w[k+1] = quo_reg;
            assign dn_w[k+1]   = n_reg;
            assign dneg_w[k+1] = neg_reg;
            assign dz_w[k+1]   = z_reg;
        end
    endgenerate

    // sign back on; an all-zero vector stays zero
    q_t u_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (dz_w[DIV_STEPS])
                    u_reg[i] <= '0;
                else if (dneg_w[DIV_STEPS][i])
                    u_reg[i] <= -q_t'(dquo_w[DIV_STEPS][i]);
                else
                    u_reg[i] <= q_t'(dquo_w[DIV_STEPS][i]);
            end
        end
    end

    assign u = u_reg;
endmodule
